FILE: hdl/safifo_pkg.sv
package safifo_pkg;

  // table geometry
  localparam int SLOT_DEPTH  = 1024;
  localparam int ENTRY_WIDTH = 32;

  // port widths fixed by the request format
  localparam int SLOT_W  = 10;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  // derived internal widths
  localparam int ADDR_W = $clog2(SLOT_DEPTH);
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);

  // request commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

FILE: hdl/slot_allocator_free_fifo.sv
// slot allocator with a fifo of freed slot indices
// request path: both ram reads are registered at accept, then the execute step loads the result register
// the block takes no new request while one is in execute, as the registered read of the slot store
//   must finish before the read-modify-write of the same request; a held result also stalls input
// reset: synchronous, active low; counters, queue pointers and handshake state clear,
//   the memories keep their contents and need no clearing pass (the high-water count bounds reads)
module slot_allocator_free_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [safifo_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [safifo_pkg::DATA_W-1:0] in_entry_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [safifo_pkg::SLOT_W-1:0] out_result_index,
  output logic [safifo_pkg::DATA_W-1:0] out_read_value,
  output logic                          out_entry_valid,
  output logic [1:0]                    out_status,
  output logic [safifo_pkg::COUNT_W-1:0] out_slots_used,
  output logic [safifo_pkg::COUNT_W-1:0] out_live_count
);

  import safifo_pkg::*;

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic in_acc;
  logic exec;

  // captured request
  logic [1:0]             cmd_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [ENTRY_WIDTH-1:0] data_r;

  // allocator bookkeeping
  logic [CNT_W-1:0]  used_cnt_r, used_cnt_nxt;
  logic [CNT_W-1:0]  alive_cnt_r, alive_cnt_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [ADDR_W-1:0] free_head_r, free_head_nxt;
  logic [ADDR_W-1:0] free_tail_r, free_tail_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   res_index_r, res_index_nxt;
  logic [DATA_W-1:0]   rd_value_r, rd_value_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [COUNT_W-1:0]  slots_used_r;
  logic [COUNT_W-1:0]  live_count_r;

  // ram ports; the slot store holds {valid mark, entry word}
  logic                   st_we;
  logic [ADDR_W-1:0]      st_waddr;
  logic [ENTRY_WIDTH:0]   st_wdata;
  logic [ENTRY_WIDTH:0]   st_rdata;
  logic                   fq_we;
  logic [ADDR_W-1:0]      fq_wdata;
  logic [ADDR_W-1:0]      fq_rdata;

  logic                   st_valid;
  logic [ENTRY_WIDTH-1:0] st_word;
  logic                   in_range;
  logic [ADDR_W-1:0]      idx_addr;

  function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] q;
    q = (p == ADDR_W'(SLOT_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // state machine: idle takes a request and issues both ram reads,
  // exec does the modify and write back and loads the result register
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // take a request only when no request is in execute and the result slot frees up
  always_comb begin
    in_stall = 1'b0;
    exec     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      S_EXEC: begin
        in_stall = 1'b1;
        exec     = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  safifo_ram #(
    .WIDTH (ENTRY_WIDTH + 1),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (in_acc),
    .raddr (ADDR_W'(in_slot_index)),
    .rdata (st_rdata)
  );

  // free queue is read at the head on every request; the word is used only by inserts
  safifo_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (SLOT_DEPTH)
  ) u_free_queue (
    .clk   (clk),
    .we    (fq_we),
    .waddr (free_tail_r),
    .wdata (fq_wdata),
    .re    (in_acc),
    .raddr (free_head_r),
    .rdata (fq_rdata)
  );

  assign st_valid = st_rdata[ENTRY_WIDTH];
  assign st_word  = st_rdata[ENTRY_WIDTH-1:0];
  assign idx_addr = ADDR_W'(idx_r);

  // an erase or read must address a slot below the high-water mark
  assign in_range = (32'(idx_r) < 32'(used_cnt_r)) && (32'(idx_r) < 32'(SLOT_DEPTH));

  // ---------------------------------------------------------------------------
  // execute: read-modify-write of the slot store and the queue pointers
  // ---------------------------------------------------------------------------
  always_comb begin
    used_cnt_nxt  = used_cnt_r;
    alive_cnt_nxt = alive_cnt_r;
    free_cnt_nxt  = free_cnt_r;
    free_head_nxt = free_head_r;
    free_tail_nxt = free_tail_r;
    st_we         = 1'b0;
    st_waddr      = idx_addr;
    st_wdata      = {1'b1, data_r};
    fq_we         = 1'b0;
    fq_wdata      = idx_addr;
    res_index_nxt = idx_r;
    rd_value_nxt  = '0;
    rd_valid_nxt  = 1'b0;
    status_nxt    = ST_OK;

    if (exec) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (free_cnt_r != '0) begin
            // reuse the oldest freed slot
            st_we         = 1'b1;
            st_waddr      = fq_rdata;
            free_head_nxt = wrap_next(free_head_r);
            free_cnt_nxt  = free_cnt_r - CNT_W'(1);
            alive_cnt_nxt = alive_cnt_r + CNT_W'(1);
            res_index_nxt = SLOT_W'(fq_rdata);
          end else if (used_cnt_r < CNT_W'(SLOT_DEPTH)) begin
            // append at the high-water mark
            st_we         = 1'b1;
            st_waddr      = ADDR_W'(used_cnt_r);
            used_cnt_nxt  = used_cnt_r + CNT_W'(1);
            alive_cnt_nxt = alive_cnt_r + CNT_W'(1);
            res_index_nxt = SLOT_W'(used_cnt_r);
          end else begin
            status_nxt    = ST_FULL;
            res_index_nxt = '0;
          end
        end
        CMD_ERASE: begin
          if (!in_range) begin
            status_nxt = ST_RANGE;
          end else if (st_valid && (free_cnt_r < CNT_W'(SLOT_DEPTH))) begin
            // clear the mark and queue the index as free
            st_we         = 1'b1;
            st_wdata      = {1'b0, st_word};
            fq_we         = 1'b1;
            free_tail_nxt = wrap_next(free_tail_r);
            free_cnt_nxt  = free_cnt_r + CNT_W'(1);
            alive_cnt_nxt = alive_cnt_r - CNT_W'(1);
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            status_nxt = ST_RANGE;
          end else if (st_valid) begin
            rd_value_nxt = DATA_W'(st_word);
            rd_valid_nxt = 1'b1;
          end
        end
        default: begin
          // unused command: no operation, index echoed
        end
      endcase
    end
  end

  // result register stays until taken
  assign out_valid_nxt = exec || (out_valid_r && out_stall);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_cnt_r  <= '0;
      alive_cnt_r <= '0;
      free_cnt_r  <= '0;
      free_head_r <= '0;
      free_tail_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_cnt_r  <= used_cnt_nxt;
      alive_cnt_r <= alive_cnt_nxt;
      free_cnt_r  <= free_cnt_nxt;
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_command;
      idx_r  <= in_slot_index;
      data_r <= ENTRY_WIDTH'(in_entry_data);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      res_index_r  <= res_index_nxt;
      rd_value_r   <= rd_value_nxt;
      rd_valid_r   <= rd_valid_nxt;
      status_r     <= status_nxt;
      slots_used_r <= COUNT_W'(used_cnt_nxt);
      live_count_r <= COUNT_W'(alive_cnt_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = res_index_r;
  assign out_read_value   = rd_value_r;
  assign out_entry_valid  = rd_valid_r;
  assign out_status       = status_r;
  assign out_slots_used   = slots_used_r;
  assign out_live_count   = live_count_r;

`ifndef SYNTH
  // every allocated slot is either live or waiting in the free queue
  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(free_cnt_r) + (CNT_W + 1)'(alive_cnt_r) == (CNT_W + 1)'(used_cnt_r))
    else $error("free plus live count differs from high-water count");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= CNT_W'(SLOT_DEPTH))
    else $error("high-water count beyond table depth");

  // a full status only when nothing was free and the table was used up
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (status_nxt == ST_FULL) |->
      (free_cnt_r == '0) && (used_cnt_r == CNT_W'(SLOT_DEPTH)))
    else $error("full status with room left");

  // execute always lands in an empty result register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !out_valid_r)
    else $error("result register overwritten");
`endif

endmodule

FILE: hdl/safifo_ram.sv
module safifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: dv/slot_allocator_free_fifo_tb.sv
module slot_allocator_free_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import safifo_pkg::*;

  // the block leaves command value three unused; it answers as a no-op
  localparam logic [1:0] CMD_NOP = 2'd3;

  // drain limit and long receiver hold-off, in clock cycles
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_OFF_LONG = 300;
  localparam int MAX_PRINTED   = 40;

  // one result as the block should report it
  typedef struct {
    logic [SLOT_W-1:0]  result_index;
    logic [DATA_W-1:0]  read_value;
    logic               entry_valid;
    logic [1:0]         status;
    logic [COUNT_W-1:0] slots_used;
    logic [COUNT_W-1:0] live_count;
  } slot_outcome_t;

  // clock, reset and every block input start at known values
  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic [1:0]          in_command    = CMD_INSERT;
  logic [SLOT_W-1:0]   in_slot_index = '0;
  logic [DATA_W-1:0]   in_entry_data = '0;
  logic                out_stall     = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_result_index;
  logic [DATA_W-1:0]   out_read_value;
  logic                out_entry_valid;
  logic [1:0]          out_status;
  logic [COUNT_W-1:0]  out_slots_used;
  logic [COUNT_W-1:0]  out_live_count;

  slot_allocator_free_fifo dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_slot_index    (in_slot_index),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_read_value   (out_read_value),
    .out_entry_valid  (out_entry_valid),
    .out_status       (out_status),
    .out_slots_used   (out_slots_used),
    .out_live_count   (out_live_count)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the slot table, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_words [SLOT_DEPTH];
  bit                shadow_live  [SLOT_DEPTH];
  logic [SLOT_W-1:0] freed_ring   [SLOT_DEPTH];
  int                freed_rd;
  int                freed_wr;
  int                freed_cnt;
  int                high_water;
  int                live_total;

  // results still owed by the block, oldest first
  slot_outcome_t     owed_results[$];

  int                error_count;
  int                results_seen;
  int                cmd_tally [4];
  int                range_errors;
  int                full_inserts;
  int                empty_reads;
  int                hold_cycles;
  int                burst_left;

  // apply one request to the shadow table and return what the block must answer
  function automatic slot_outcome_t slot_table_outcome(input logic [1:0] cmd,
                                                       input logic [SLOT_W-1:0] idx,
                                                       input logic [DATA_W-1:0] data);
    slot_outcome_t res;
    int            slot;
    res.result_index = idx;
    res.read_value   = '0;
    res.entry_valid  = 1'b0;
    res.status       = ST_OK;
    if (cmd == CMD_INSERT) begin
      // oldest freed slot first, else append at the high-water mark
      if (freed_cnt > 0) begin
        slot      = freed_ring[freed_rd];
        freed_rd  = (freed_rd + 1) % SLOT_DEPTH;
        freed_cnt = freed_cnt - 1;
      end else if (high_water < SLOT_DEPTH) begin
        slot       = high_water;
        high_water = high_water + 1;
      end else begin
        slot             = 0;
        res.status       = ST_FULL;
        res.result_index = '0;
      end
      if (res.status == ST_OK) begin
        shadow_words[slot] = data;
        shadow_live[slot]  = 1'b1;
        live_total         = live_total + 1;
        res.result_index   = SLOT_W'(slot);
      end
    end else if (cmd == CMD_ERASE || cmd == CMD_READ) begin
      if (int'(idx) >= high_water) begin
        res.status = ST_RANGE;
      end else if (cmd == CMD_ERASE) begin
        // erasing an empty slot leaves everything as it is
        if (shadow_live[idx] && freed_cnt < SLOT_DEPTH) begin
          shadow_live[idx]     = 1'b0;
          freed_ring[freed_wr] = idx;
          freed_wr             = (freed_wr + 1) % SLOT_DEPTH;
          freed_cnt            = freed_cnt + 1;
          live_total           = live_total - 1;
        end
      end else if (shadow_live[idx]) begin
        res.read_value  = shadow_words[idx];
        res.entry_valid = 1'b1;
      end
    end
    res.slots_used = COUNT_W'(high_water);
    res.live_count = COUNT_W'(live_total);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count = error_count + 1;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, results_seen, what,
               got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side: drive at the rising edge, hold until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] cmd, input logic [SLOT_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    slot_outcome_t res;
    in_command    <= cmd;
    in_slot_index <= idx;
    in_entry_data <= data;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    // taken at this edge: predict in request order
    res = slot_table_outcome(cmd, idx, data);
    owed_results = {owed_results, res};
    cmd_tally[cmd] = cmd_tally[cmd] + 1;
    if (res.status == ST_RANGE) range_errors = range_errors + 1;
    if (res.status == ST_FULL) full_inserts = full_inserts + 1;
    if (cmd == CMD_READ && res.status == ST_OK && !res.entry_valid) begin
      empty_reads = empty_reads + 1;
    end
  endtask

  // bursts of random length; now and then a long burst with no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left = burst_left - 1;
  endtask

  // sender goes quiet until the block has answered everything
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited = waited + 1;
    end
    if (owed_results.size() != 0) begin
      report_mismatch("results still owed after drain", owed_results.size(), 0);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_entry_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // mostly slots below the high-water mark, some just at it, some anywhere
  function automatic logic [SLOT_W-1:0] pick_slot(input bit whole_range);
    int unsigned roll;
    roll = $urandom_range(99);
    if (whole_range || high_water == 0 || roll < 8) return SLOT_W'($urandom_range(SLOT_DEPTH - 1));
    if (roll < 14 && high_water < SLOT_DEPTH) return SLOT_W'(high_water);
    return SLOT_W'($urandom_range(high_water - 1));
  endfunction

  function automatic logic [1:0] pick_command(input int insert_weight);
    int roll;
    roll = $urandom_range(99);
    if (roll < insert_weight) return CMD_INSERT;
    if (roll < insert_weight + (95 - insert_weight) / 2) return CMD_ERASE;
    if (roll < 95) return CMD_READ;
    return CMD_NOP;
  endfunction

  task automatic send_random_request(input bit whole_range);
    int         weight;
    logic [1:0] cmd;
    // keep the live set moderate so reads and erases mostly land on real entries
    weight = whole_range ? 35 : ((live_total < 48) ? 50 : 30);
    cmd    = pick_command(weight);
    pace_sender();
    send_request(cmd, pick_slot(whole_range), pick_entry_word());
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern with phases, plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  int stall_mode;
  int stall_phase_left;

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(3);
        stall_phase_left = $urandom_range(20, 120);
      end
      stall_phase_left = stall_phase_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(3) == 0);
        2:       out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(9) < 7);
      endcase
    end
  end

  // every accepted result is checked against the oldest owed one
  always @(posedge clk) begin
    slot_outcome_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen = results_seen + 1;
      if (owed_results.size() == 0) begin
        report_mismatch("result with no request waiting, index", out_result_index, 0);
      end else begin
        want = owed_results.pop_front();
        if (out_result_index !== want.result_index) begin
          report_mismatch("result_index", out_result_index, want.result_index);
        end
        if (out_read_value !== want.read_value) begin
          report_mismatch("read_value", out_read_value, want.read_value);
        end
        if (out_entry_valid !== want.entry_valid) begin
          report_mismatch("entry_valid", out_entry_valid, want.entry_valid);
        end
        if (out_status !== want.status) begin
          report_mismatch("status", out_status, want.status);
        end
        if (out_slots_used !== want.slots_used) begin
          report_mismatch("slots_used", out_slots_used, want.slots_used);
        end
        if (out_live_count !== want.live_count) begin
          report_mismatch("live_count", out_live_count, want.live_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing allocated yet: every erase and read is out of range, no-op echoes
  task automatic test_empty_table();
    send_request(CMD_READ, '0, '0);
    send_request(CMD_ERASE, '0, '1);
    send_request(CMD_READ, '1, '1);
    send_request(CMD_ERASE, '1, '0);
    send_request(CMD_NOP, '1, '1);
  endtask

  // appends, reads, erase of live and empty slots, reuse in freed order
  task automatic test_insert_erase_reuse();
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, '0, 32'ha5a5_a5a5);
    send_request(CMD_INSERT, '0, 32'h5a5a_5a5a);
    send_request(CMD_READ, 10'd0, '0);
    send_request(CMD_READ, 10'd1, '0);
    send_request(CMD_READ, 10'd3, '0);
    send_request(CMD_READ, 10'd4, '0);
    send_request(CMD_ERASE, 10'd1, '0);
    send_request(CMD_READ, 10'd1, '0);
    send_request(CMD_ERASE, 10'd1, '0);
    send_request(CMD_ERASE, 10'd3, '0);
    send_request(CMD_ERASE, 10'd0, '0);
    // freed order was 1, 3, 0; the fourth insert appends again
    send_request(CMD_INSERT, '0, 32'h1234_5678);
    send_request(CMD_INSERT, '1, 32'h8000_0001);
    send_request(CMD_INSERT, '0, 32'h7fff_fffe);
    send_request(CMD_INSERT, '1, 32'hdead_beef);
    send_request(CMD_READ, 10'd1, '1);
    send_request(CMD_READ, 10'd4, '1);
    send_request(CMD_NOP, '0, '1);
  endtask

  // random mix of requests, with one full pause of the sender midway
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_random_request(1'b0);
    end
  endtask

  // long receiver hold-off while requests keep coming back to back
  task automatic test_backpressure(input int count);
    hold_cycles = HOLD_OFF_LONG;
    for (int i = 0; i < count; i++) begin
      send_request(pick_command(40), pick_slot(1'b0), pick_entry_word());
    end
    wait_for_results();
  endtask

  // insert until every slot is taken, then inserts into a full table, an erase and reuse of its slot
  task automatic test_fill_table();
    while (high_water < SLOT_DEPTH || freed_cnt > 0) begin
      pace_sender();
      send_request(CMD_INSERT, SLOT_W'($urandom_range(SLOT_DEPTH - 1)), pick_entry_word());
    end
    send_request(CMD_INSERT, '0, '1);
    send_request(CMD_INSERT, '1, '0);
    send_request(CMD_READ, '1, '0);
    send_request(CMD_ERASE, '1, '0);
    send_request(CMD_INSERT, '0, 32'hcafe_f00d);
    send_request(CMD_READ, '1, '0);
    send_request(CMD_INSERT, '0, '0);
  endtask

  // whole index range is now valid: churn erases, reads and reuse across it
  task automatic test_full_table_churn(input int count);
    for (int i = 0; i < count; i++) begin
      send_random_request(1'b1);
    end
  endtask

  initial begin
    error_count      = 0;
    results_seen     = 0;
    freed_rd         = 0;
    freed_wr         = 0;
    freed_cnt        = 0;
    high_water       = 0;
    live_total       = 0;
    range_errors     = 0;
    full_inserts     = 0;
    empty_reads      = 0;
    hold_cycles      = 0;
    burst_left       = 0;
    stall_mode       = 0;
    stall_phase_left = 0;
    foreach (cmd_tally[c]) cmd_tally[c] = 0;

    // reset is held low, then released at a rising edge
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_insert_erase_reuse();
    test_random_mix(200);
    test_backpressure(120);
    test_fill_table();
    test_full_table_churn(100);

    // everything sent: wait out the owed results, then let the block idle before the last check
    wait_for_results();
    repeat (10) @(posedge clk);
    if (owed_results.size() != 0) begin
      report_mismatch("results never delivered", owed_results.size(), 0);
    end

    $display("covered %0d inserts, %0d erases, %0d reads, %0d no-ops; %0d results checked",
             cmd_tally[CMD_INSERT], cmd_tally[CMD_ERASE], cmd_tally[CMD_READ],
             cmd_tally[CMD_NOP], results_seen);
    $display("out-of-range accesses %0d, full-table inserts %0d, reads of freed slots %0d",
             range_errors, full_inserts, empty_reads);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: requests or results stopped moving");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/safifo_pkg.sv
hdl/safifo_ram.sv
hdl/slot_allocator_free_fifo.sv
dv/slot_allocator_free_fifo_tb.sv
